FILE: rtl/core/vca_pkg.sv
// ----------------------------------------------------------------------------
// vca_pkg
// shared types and constants for the voice channel allocator
// ----------------------------------------------------------------------------
package vca_pkg;

   localparam int NUM_VOICES_DEFAULT = 32;

   localparam int ENTITY_W      = 16;
   localparam int CHAN_W        = 4;
   localparam int LENGTH_W      = 24;
   localparam int TIME_W        = 31;
   localparam int END_W         = 32;
   localparam int VOICE_INDEX_W = 8;
   localparam int COMMAND_W     = 2;

   localparam logic [COMMAND_W-1:0] CMD_START    = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_STOP     = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_STOP_ALL = 2'd2;
   localparam logic [COMMAND_W-1:0] CMD_NOP      = 2'd3;

   localparam logic signed [END_W-1:0] LIFE_LIMIT = 32'sh7fffffff;
   localparam logic [CHAN_W-1:0]       CHAN_ANY   = 4'hf;
   localparam logic [CHAN_W-1:0]       CHAN_NONE  = 4'h0;

   // search word handed from cell to cell
   typedef struct packed {
      logic                       valid;
      logic                       done;
      logic                       hit;
      logic signed [END_W-1:0]    best;
      logic [VOICE_INDEX_W-1:0]   idx;
   } scan_token_type;

   // request fields held for the whole scan
   typedef struct packed {
      logic [COMMAND_W-1:0]       command;
      logic [ENTITY_W-1:0]        entity;
      logic [CHAN_W-1:0]          chan;
      logic [TIME_W-1:0]          now;
      logic [ENTITY_W-1:0]        view;
   } scan_request_type;

   // table update broadcast to all cells
   typedef struct packed {
      logic                       write;
      logic                       stop;
      logic                       clear;
      logic [VOICE_INDEX_W-1:0]   idx;
      logic [ENTITY_W-1:0]        entity;
      logic [CHAN_W-1:0]          chan;
      logic [END_W-1:0]           end_time;
      logic                       active;
   } table_update_type;

endpackage

FILE: rtl/core/voice_channel_allocator.sv
// start and stop: accept sets the launch register, the search word walks the row of
//   voice cells one cell per cycle, the strobe is registered from the last cell,
//   busy stays high until then; the table is written as the word leaves the last cell
// stop all and no-op: result the cycle after accept, next item the same cycle
// synchronous reset clears the voice table and the view entity
// each result stands for one cycle only; the receiver cannot stall it
// ----------------------------------------------------------------------------
// voice_channel_allocator
// picks, steals and releases mixer voices held in a chain of voice cells
// ----------------------------------------------------------------------------
module voice_channel_allocator #(
   parameter int NUM_VOICES = vca_pkg::NUM_VOICES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [vca_pkg::COMMAND_W-1:0]        req_command,
   input  logic [vca_pkg::ENTITY_W-1:0]         req_entity,
   input  logic signed [vca_pkg::CHAN_W-1:0]    req_ent_channel,
   input  logic [vca_pkg::LENGTH_W-1:0]         req_sound_length,
   input  logic [vca_pkg::TIME_W-1:0]           req_painted_time,
   input  logic                                 req_playable,
   output logic                                 rsp_strobe,
   output logic                                 rsp_found,
   output logic [vca_pkg::VOICE_INDEX_W-1:0]    rsp_voice_index,
   input  logic                                 csr_write_enable,
   input  logic [vca_pkg::ENTITY_W-1:0]         csr_write_data
);
   import vca_pkg::*;

   logic                      busy_ff, busy_in;
   logic                      launch_ff, launch_in;
   logic [ENTITY_W-1:0]       view_ff, view_in;
   scan_request_type          request_ff;
   logic [LENGTH_W-1:0]       length_ff;
   logic                      playable_ff;
   logic                      strobe_ff, strobe_in;
   logic                      found_ff, found_in;
   logic [VOICE_INDEX_W-1:0]  index_ff, index_in;

   logic                      accept;
   logic                      accept_scan;
   scan_token_type            chain [NUM_VOICES+1];
   scan_token_type            tail;
   table_update_type          update;

   assign accept      = start && !busy_ff;
   assign accept_scan = accept && ((req_command == CMD_START) || (req_command == CMD_STOP));
   assign tail        = chain[NUM_VOICES];

   // search word enters the first cell the cycle after accept
   always_comb begin
      chain[0].valid = launch_ff;
      chain[0].done  = 1'b0;
      chain[0].hit   = 1'b0;
      chain[0].best  = LIFE_LIMIT;
      chain[0].idx   = '0;
   end

   always_comb begin
      update.write    = tail.valid && tail.hit && (request_ff.command == CMD_START);
      update.stop     = tail.valid && tail.hit && (request_ff.command == CMD_STOP);
      update.clear    = accept && (req_command == CMD_STOP_ALL);
      update.idx      = tail.idx;
      update.entity   = request_ff.entity;
      update.chan     = request_ff.chan;
      update.end_time = playable_ff ?
                        ({1'b0, request_ff.now} + {{(END_W-LENGTH_W){1'b0}}, length_ff}) : '0;
      update.active   = playable_ff;
   end

   genvar i;
   generate
      for (i = 0; i < NUM_VOICES; i++) begin : g_cell
         vca_voice_cell #(
            .CELL_INDEX (VOICE_INDEX_W'(i))
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .request   (request_ff),
            .update    (update),
            .token_in  (chain[i]),
            .token_out (chain[i+1])
         );
      end
   endgenerate

   always_comb begin
      busy_in   = busy_ff;
      launch_in = accept_scan;
      view_in   = csr_write_enable ? csr_write_data : view_ff;
      strobe_in = 1'b0;
      found_in  = found_ff;
      index_in  = index_ff;
      if (accept_scan) begin
         busy_in = 1'b1;
      end else if (accept) begin
         // stop all and no-op answer at once
         strobe_in = 1'b1;
         found_in  = 1'b0;
         index_in  = '0;
      end
      if (tail.valid) begin
         busy_in   = 1'b0;
         strobe_in = 1'b1;
         found_in  = tail.hit;
         index_in  = tail.hit ? tail.idx : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         launch_ff <= 1'b0;
         view_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         launch_ff <= launch_in;
         view_ff   <= view_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      index_ff <= index_in;
      if (accept) begin
         request_ff.command <= req_command;
         request_ff.entity  <= req_entity;
         request_ff.chan    <= req_ent_channel;
         request_ff.now     <= req_painted_time;
         request_ff.view    <= view_ff;
         length_ff          <= req_sound_length;
         playable_ff        <= req_playable;
      end
   end

   assign busy            = busy_ff;
   assign rsp_strobe      = strobe_ff;
   assign rsp_found       = found_ff;
   assign rsp_voice_index = index_ff;

endmodule

FILE: rtl/core/vca_voice_cell.sv
// ----------------------------------------------------------------------------
// vca_voice_cell
// one voice of the table plus one step of the search chain
// ----------------------------------------------------------------------------
module vca_voice_cell #(
   parameter logic [vca_pkg::VOICE_INDEX_W-1:0] CELL_INDEX = '0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  vca_pkg::scan_request_type request,
   input  vca_pkg::table_update_type update,
   input  vca_pkg::scan_token_type   token_in,
   output vca_pkg::scan_token_type   token_out
);
   import vca_pkg::*;

   logic [ENTITY_W-1:0]  owner_ff, owner_in;
   logic [CHAN_W-1:0]    chan_ff, chan_in;
   logic [END_W-1:0]     end_ff, end_in;
   logic                 active_ff, active_in;
   scan_token_type       token_ff, token_in_next;

   logic                    owner_hit;
   logic                    start_match;
   logic                    stop_match;
   logic                    is_protected;
   logic signed [END_W-1:0] life;
   logic                    better;
   logic                    selected;

   always_comb begin
      owner_hit   = (owner_ff == request.entity);
      start_match = (request.chan != CHAN_NONE) && owner_hit &&
                    ((chan_ff == request.chan) || (request.chan == CHAN_ANY));
      stop_match  = owner_hit && (chan_ff == request.chan);
      is_protected = (owner_ff == request.view) && (request.entity != request.view) &&
                     active_ff;
      life   = signed'(end_ff - {1'b0, request.now});
      better = (life < token_in.best);

      token_in_next = token_in;
      if (token_in.valid && !token_in.done) begin
         case (request.command)
            CMD_START: begin
               if (start_match) begin
                  token_in_next.done = 1'b1;
                  token_in_next.hit  = 1'b1;
                  token_in_next.idx  = CELL_INDEX;
               end else if (!is_protected && better) begin
                  token_in_next.best = life;
                  token_in_next.hit  = 1'b1;
                  token_in_next.idx  = CELL_INDEX;
               end
            end
            CMD_STOP: begin
               if (stop_match) begin
                  token_in_next.done = 1'b1;
                  token_in_next.hit  = 1'b1;
                  token_in_next.idx  = CELL_INDEX;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      selected  = (update.idx == CELL_INDEX);
      owner_in  = owner_ff;
      chan_in   = chan_ff;
      end_in    = end_ff;
      active_in = active_ff;
      if (update.clear) begin
         owner_in  = '0;
         chan_in   = '0;
         end_in    = '0;
         active_in = 1'b0;
      end else if (update.write && selected) begin
         owner_in  = update.entity;
         chan_in   = update.chan;
         end_in    = update.end_time;
         active_in = update.active;
      end else if (update.stop && selected) begin
         end_in    = '0;
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff       <= '0;
         chan_ff        <= '0;
         end_ff         <= '0;
         active_ff      <= 1'b0;
         token_ff.valid <= 1'b0;
      end else begin
         owner_ff       <= owner_in;
         chan_ff        <= chan_in;
         end_ff         <= end_in;
         active_ff      <= active_in;
         token_ff.valid <= token_in_next.valid;
      end
   end

   always_ff @(posedge clock) begin
      token_ff.done <= token_in_next.done;
      token_ff.hit  <= token_in_next.hit;
      token_ff.best <= token_in_next.best;
      token_ff.idx  <= token_in_next.idx;
   end

   assign token_out = token_ff;

endmodule
